/* hdl/mlcf_pkg.sv */
// shared types, widths and codes for the multi load-cell fusion block
package mlcf_pkg;

    // sensor slots and derived widths
    localparam int MAX_SENSORS = 4;
    localparam int SIDX_W      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int NCNT_W      = $clog2(MAX_SENSORS + 1);
    localparam int SAMPLE_W    = 32;
    localparam int SUM_W       = SAMPLE_W + SIDX_W + 1;
    localparam int MAG_W       = SUM_W - 1;
    localparam int DIV_CNT_W   = $clog2(MAG_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int COUNT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_ATTACHED = 2'd2;

    // item operation codes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_PROCESS = 2'd1;
    localparam logic [1:0] OP_ARM     = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic [1:0]                 sensor_index;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_error;
        logic                       arm_active;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] fused_value;
        logic                       from_error;
        logic                       to_probe;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic store_sample;
        logic arm;
        logic clear_new;
        logic set_err;
        logic acc_start;
        logic acc_step;
        logic div_load;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic armed;
        logic new_data;
        logic sample_ok;
        logic all_updated;
        logic any_error;
        logic acc_last;
        logic div_last;
    } dp_status_t;

endpackage

/* hdl/mlcf_ctrl.sv */
// sequencing controller for the multi load-cell fusion block
module mlcf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_op,
    input  logic               out_ready,
    input  mlcf_pkg::dp_status_t status,
    output logic               in_ready,
    output logic               out_valid,
    output mlcf_pkg::ctrl_cmd_t cmd
);
    import mlcf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_DLOAD = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_SAMPLE:
                        begin
                            cmd.store_sample = status.sample_ok;
                        end
                        OP_ARM:
                        begin
                            cmd.arm = 1'b1;
                        end
                        OP_PROCESS:
                        begin
                            if (status.armed && status.new_data)
                            begin
                                cmd.clear_new = 1'b1;
                                if (status.all_updated)
                                begin
                                    if (status.any_error)
                                    begin
                                        cmd.set_err = 1'b1;
                                        state_next  = S_OUT;
                                    end
                                    else
                                    begin
                                        cmd.acc_start = 1'b1;
                                        state_next    = S_ACC;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (status.acc_last)
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/mlcf_datapath.sv */
// sensor store, accumulator, serial divider and result register
module mlcf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mlcf_pkg::in_item_t                  in_data,
    input  logic                                cfg_wr_en,
    input  logic [mlcf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlcf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  mlcf_pkg::ctrl_cmd_t                 cmd,
    output mlcf_pkg::dp_status_t                status,
    output mlcf_pkg::out_item_t                 out_data
);
    import mlcf_pkg::*;

    localparam logic [MAG_W-1:0] POS_LIM =
        {{(MAG_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [MAG_W-1:0] NEG_LIM = POS_LIM + MAG_W'(1);

    // configuration registers
    logic [COUNT_W-1:0]     sensor_count_reg;
    logic [MAX_SENSORS-1:0] invert_mask_reg;
    logic                   probe_reg;

    // sensor state
    logic                       armed_reg;
    logic                       new_data_reg;
    logic [MAX_SENSORS-1:0]     updated_reg;
    logic [MAX_SENSORS-1:0]     error_reg;
    logic signed [SAMPLE_W-1:0] sample_reg [MAX_SENSORS];

    // fusion working registers
    logic [SIDX_W-1:0]          acc_idx_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       neg_reg;
    logic [MAG_W-1:0]           quo_reg;
    logic [NCNT_W-1:0]          rem_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic                       err_sel_reg;
    logic signed [SAMPLE_W-1:0] err_value_reg;
    out_item_t                  out_reg;

    logic [NCNT_W-1:0]          n_act;
    logic                       all_updated;
    logic                       any_error;
    logic [SIDX_W-1:0]          err_idx;
    logic signed [SAMPLE_W-1:0] cur_sample;
    logic signed [SUM_W-1:0]    addend;
    logic [SUM_W-1:0]           sum_mag;
    logic [NCNT_W:0]            rem_sh;
    logic                       rem_ge;
    logic [NCNT_W:0]            rem_sub;
    logic [MAG_W-1:0]           quo_neg;
    logic signed [SAMPLE_W-1:0] avg_value;

    // active sensor count, zero means one
    always_comb
    begin
        if (sensor_count_reg == '0)
        begin
            n_act = NCNT_W'(1);
        end
        else if (32'(sensor_count_reg) > MAX_SENSORS)
        begin
            n_act = NCNT_W'(MAX_SENSORS);
        end
        else
        begin
            n_act = NCNT_W'(sensor_count_reg);
        end
    end

    // readiness and lowest errored slot
    always_comb
    begin
        all_updated = 1'b1;
        any_error   = 1'b0;
        err_idx     = '0;
        for (int i = MAX_SENSORS - 1; i >= 0; i--)
        begin
            if (NCNT_W'(i) < n_act)
            begin
                all_updated = all_updated & updated_reg[i];
                if (error_reg[i])
                begin
                    any_error = 1'b1;
                    err_idx   = SIDX_W'(i);
                end
            end
        end
    end

    // one slot per cycle into the sum
    assign cur_sample = sample_reg[acc_idx_reg];
    assign addend     = {{(SUM_W - SAMPLE_W){cur_sample[SAMPLE_W-1]}}, cur_sample};
    assign sum_next   = invert_mask_reg[acc_idx_reg] ? (sum_reg - addend)
                                                     : (sum_reg + addend);
    assign sum_mag    = sum_reg[SUM_W-1] ? (-sum_reg) : sum_reg;

    // restoring divide step by the sensor count
    assign rem_sh  = {rem_reg, quo_reg[MAG_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, n_act});
    assign rem_sub = rem_sh - {1'b0, n_act};

    // sign restore and saturation
    assign quo_neg = -quo_reg;
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > NEG_LIM)
            begin
                avg_value = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            end
            else
            begin
                avg_value = quo_neg[SAMPLE_W-1:0];
            end
        end
        else
        begin
            if (quo_reg > POS_LIM)
            begin
                avg_value = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            end
            else
            begin
                avg_value = quo_reg[SAMPLE_W-1:0];
            end
        end
    end

    assign status.armed       = armed_reg;
    assign status.new_data    = new_data_reg;
    assign status.sample_ok   = armed_reg && (NCNT_W'(in_data.sensor_index) < n_act);
    assign status.all_updated = all_updated;
    assign status.any_error   = any_error;
    assign status.acc_last    = ((NCNT_W'(acc_idx_reg) + NCNT_W'(1)) == n_act);
    assign status.div_last    = (div_cnt_reg == DIV_CNT_W'(MAG_W - 1));
    assign out_data           = out_reg;

    // configuration and flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= COUNT_W'(1);
            invert_mask_reg  <= '0;
            probe_reg        <= 1'b0;
            armed_reg        <= 1'b0;
            new_data_reg     <= 1'b0;
            updated_reg      <= '0;
            error_reg        <= '0;
            err_sel_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SENSOR_COUNT:   sensor_count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_INVERT_MASK:    invert_mask_reg  <= cfg_data[MAX_SENSORS-1:0];
                    CFG_PROBE_ATTACHED: probe_reg        <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.store_sample)
            begin
                updated_reg[in_data.sensor_index] <= 1'b1;
                error_reg[in_data.sensor_index]   <= in_data.sample_error;
                new_data_reg                      <= 1'b1;
            end
            if (cmd.arm)
            begin
                armed_reg    <= in_data.arm_active;
                updated_reg  <= '0;
                error_reg    <= '0;
                new_data_reg <= 1'b0;
            end
            if (cmd.clear_new)
            begin
                new_data_reg <= 1'b0;
            end
            if (cmd.set_err)
            begin
                err_sel_reg <= 1'b1;
            end
            else if (cmd.acc_start)
            begin
                err_sel_reg <= 1'b0;
            end
        end
    end

    // sample store, accumulator, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.store_sample)
        begin
            sample_reg[in_data.sensor_index] <= in_data.sample_value;
        end
        if (cmd.set_err)
        begin
            err_value_reg <= sample_reg[err_idx];
        end
        if (cmd.acc_start)
        begin
            sum_reg     <= '0;
            acc_idx_reg <= '0;
        end
        else if (cmd.acc_step)
        begin
            sum_reg     <= sum_next;
            acc_idx_reg <= acc_idx_reg + SIDX_W'(1);
        end
        if (cmd.div_load)
        begin
            neg_reg     <= sum_reg[SUM_W-1];
            quo_reg     <= sum_mag[MAG_W-1:0];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[MAG_W-2:0], rem_ge};
            rem_reg     <= rem_ge ? rem_sub[NCNT_W-1:0] : rem_sh[NCNT_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.load_out)
        begin
            out_reg.fused_value <= err_sel_reg ? err_value_reg : avg_value;
            out_reg.from_error  <= err_sel_reg;
            out_reg.to_probe    <= err_sel_reg ? 1'b0 : probe_reg;
        end
    end

endmodule

/* hdl/multi_load_cell_fusion.sv */
// top level of the multi load-cell fusion block
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_data    (in_item_t)
//   out       output     out_valid / out_ready  out_data   (out_item_t)
//   cfg       input      cfg_wr_en              cfg_index, cfg_data
//
// sample and arm items are handled while idle; a process item with no result
// stays idle, an errored result goes straight to the final state, and for an
// averaged result the sum walks one slot a cycle over the n active sensors,
// then a serial divider retires one quotient bit a cycle over a 34-bit magnitude.
// reset restores the register defaults and leaves the block disarmed.
// a finished result sits in the output register while new items are taken;
// the next result waits in the final state until that register frees up.
module multi_load_cell_fusion (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mlcf_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mlcf_pkg::out_item_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [mlcf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlcf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mlcf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    mlcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.op),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // storage and arithmetic
    mlcf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register loaded while a transfer is pending");

    // samples land only while armed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_sample |-> status.armed)
        else $error("sample stored while disarmed");

    // averaging starts only with every sensor reported and none in error
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_start |-> (status.all_updated && !status.any_error))
        else $error("averaging started without a clean full set");

    // a process that starts fusion leaves no new data behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_start || cmd.set_err) |=> !status.new_data)
        else $error("new data flag not cleared by process");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the multi load-cell fusion block
`timescale 1ns / 1ps

module testbench;
    import mlcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_ITEMS   = 600;
    localparam int RANDOM_PHASES  = 9;
    localparam longint FUSED_MAX  = 64'sd2147483647;
    localparam longint FUSED_MIN  = -FUSED_MAX - 1;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    // codes with no name in the package
    localparam logic [1:0]           OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of the registers and sensor slots
    logic [COUNT_W-1:0]         cfg_count  = 3'd1;
    logic [3:0]                 cfg_invert = 4'd0;
    logic                       cfg_probe  = 1'b0;
    logic signed [SAMPLE_W-1:0] slot_sample  [MAX_SENSORS] = '{default: '0};
    logic                       slot_updated [MAX_SENSORS] = '{default: 1'b0};
    logic                       slot_error   [MAX_SENSORS] = '{default: 1'b0};
    logic                       fresh_data = 1'b0;
    logic                       is_armed   = 1'b0;

    out_item_t pending_fused[$];
    bit        stall_en = 1'b1;

    int error_count       = 0;
    int items_sent        = 0;
    int items_acting      = 0;
    int results_checked   = 0;
    int error_results     = 0;
    int averaged_results  = 0;
    int saturated_results = 0;
    int settings_done     = 0;

    multi_load_cell_fusion u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic int fused_count();
        if (cfg_count == 0)
            return 1;
        if (cfg_count > MAX_SENSORS)
            return MAX_SENSORS;
        return int'(cfg_count);
    endfunction

    // advance the predicted state by one accepted item, queue any result
    task automatic predict_fusion(input in_item_t it);
        int        n;
        int        i;
        int        first_err;
        bit        all_in;
        longint    total;
        longint    mean;
        out_item_t res;
        n = fused_count();
        items_sent++;
        case (it.op)
            OP_SAMPLE:
            begin
                if (is_armed && int'(it.sensor_index) < n)
                begin
                    slot_sample[it.sensor_index]  = it.sample_value;
                    slot_updated[it.sensor_index] = 1'b1;
                    slot_error[it.sensor_index]   = it.sample_error;
                    fresh_data = 1'b1;
                    items_acting++;
                end
            end
            OP_ARM:
            begin
                for (i = 0; i < MAX_SENSORS; i++)
                begin
                    slot_updated[i] = 1'b0;
                    slot_error[i]   = 1'b0;
                end
                fresh_data = 1'b0;
                is_armed   = it.arm_active;
                items_acting++;
            end
            OP_PROCESS:
            begin
                if (is_armed && fresh_data)
                begin
                    fresh_data = 1'b0;
                    items_acting++;
                    all_in    = 1'b1;
                    first_err = -1;
                    for (i = 0; i < n; i++)
                    begin
                        if (!slot_updated[i])
                            all_in = 1'b0;
                        if (slot_error[i] && first_err < 0)
                            first_err = i;
                    end
                    if (all_in && first_err >= 0)
                    begin
                        // errored sample goes out as stored, no sign adjustment
                        res.fused_value = slot_sample[first_err];
                        res.from_error  = 1'b1;
                        res.to_probe    = 1'b0;
                        pending_fused.push_back(res);
                        error_results++;
                    end
                    else if (all_in)
                    begin
                        total = 0;
                        for (i = 0; i < n; i++)
                        begin
                            if (cfg_invert[i])
                                total -= longint'(slot_sample[i]);
                            else
                                total += longint'(slot_sample[i]);
                        end
                        mean = total / n;
                        if (mean > FUSED_MAX || mean < FUSED_MIN)
                            saturated_results++;
                        if (mean > FUSED_MAX)
                            mean = FUSED_MAX;
                        if (mean < FUSED_MIN)
                            mean = FUSED_MIN;
                        res.fused_value = SAMPLE_W'(mean);
                        res.from_error  = 1'b0;
                        res.to_probe    = cfg_probe;
                        pending_fused.push_back(res);
                        averaged_results++;
                    end
                end
            end
            default:
            begin
                // reserved op leaves everything alone
            end
        endcase
    endtask

    // one transfer on the input channel, with random idle cycles ahead of it
    task automatic send_item(input in_item_t it);
        while (stall_en && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_fusion(it);
    endtask

    // item with every field random, then the fields that matter overridden
    function automatic in_item_t any_item(input logic [1:0] op);
        in_item_t it;
        it.op           = op;
        it.sensor_index = 2'($urandom_range(3));
        it.sample_value = $urandom;
        it.sample_error = 1'($urandom_range(1));
        it.arm_active   = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic send_sample(input int idx, input logic signed [SAMPLE_W-1:0] value,
                               input logic err);
        in_item_t it;
        it = any_item(OP_SAMPLE);
        it.sensor_index = 2'(idx);
        it.sample_value = value;
        it.sample_error = err;
        send_item(it);
    endtask

    task automatic send_process();
        send_item(any_item(OP_PROCESS));
    endtask

    task automatic send_arm(input logic active);
        in_item_t it;
        it = any_item(OP_ARM);
        it.arm_active = active;
        send_item(it);
    endtask

    task automatic send_noise();
        send_item(any_item(OP_RESERVED));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    // wait for every result, then let a busy block finish its pass
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_fused.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers, unused bits of the data random, plus the unmapped index
    task automatic write_config(input logic [COUNT_W-1:0] count, input logic [3:0] mask,
                                input logic probe);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SENSOR_COUNT;
        cfg_data  <= {1'($urandom_range(1)), count};
        @(posedge clk);
        cfg_index <= CFG_INVERT_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= CFG_PROBE_ATTACHED;
        cfg_data  <= {3'($urandom_range(7)), probe};
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 4'($urandom_range(15));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_count  = count;
        cfg_invert = mask;
        cfg_probe  = probe;
        settings_done++;
    endtask

    // fused result check and output backpressure
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fused.size() == 0)
                report_mismatch($sformatf("result %0d with nothing pending",
                                          out_data.fused_value));
            else
            begin
                want = pending_fused.pop_front();
                results_checked++;
                if (out_data.fused_value !== want.fused_value)
                    report_mismatch($sformatf("fused_value %0d, expected %0d",
                                              out_data.fused_value, want.fused_value));
                if (out_data.from_error !== want.from_error)
                    report_mismatch($sformatf("from_error %b, expected %b",
                                              out_data.from_error, want.from_error));
                if (out_data.to_probe !== want.to_probe)
                    report_mismatch($sformatf("to_probe %b, expected %b",
                                              out_data.to_probe, want.to_probe));
            end
        end
        out_ready <= !(stall_en && $urandom_range(99) < 31);
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // disarmed block, missing data, sensor beyond the count, reserved op
    task automatic test_disarmed_start();
        send_sample(0, 5, 1'b0);
        send_process();
        send_arm(1'b1);
        send_process();
        send_sample(1, SAMPLE_MAX, 1'b1);
        send_process();
        send_sample(0, SAMPLE_MIN, 1'b0);
        send_process();
        send_noise();
        settle();
    endtask

    // single inverted minimum reading saturates to the positive maximum
    task automatic test_inverted_overflow();
        write_config(3'd1, 4'b0001, 1'b1);
        send_sample(0, SAMPLE_MIN, 1'b0);
        send_process();
        settle();
    endtask

    // count above range, incomplete set, lowest errored sensor wins
    task automatic test_error_priority();
        write_config(3'd7, 4'hF, 1'b0);
        send_arm(1'b1);
        send_sample(0, SAMPLE_MAX, 1'b0);
        send_sample(1, SAMPLE_MAX, 1'b0);
        send_sample(2, SAMPLE_MAX, 1'b0);
        send_process();
        send_sample(3, -7, 1'b1);
        send_sample(2, 123, 1'b1);
        send_process();
        settle();
    endtask

    // disarm drops samples, count zero acts as one sensor
    task automatic test_disarm_and_zero_count();
        send_arm(1'b0);
        send_sample(0, 9, 1'b0);
        send_process();
        settle();
        write_config(3'd0, 4'h0, 1'b1);
        send_arm(1'b1);
        send_sample(0, -1, 1'b0);
        send_process();
        settle();
    endtask

    // mostly full sensor sets followed by a process tick, some noise mixed in
    task automatic fusion_round();
        int n;
        int start;
        int i;
        int pick;
        n    = fused_count();
        pick = $urandom_range(99);
        if (!is_armed && pick < 85)
            send_arm(1'b1);
        else if (pick < 5)
            send_noise();
        else if (pick < 9)
            send_arm(1'($urandom_range(1)));
        else if (pick < 13)
            send_sample($urandom_range(3), pick_sample(), 1'($urandom_range(1)));
        else if (pick < 16)
            send_process();
        else
        begin
            start = $urandom_range(n - 1);
            for (i = 0; i < n; i++)
                if (n == 1 || $urandom_range(99) >= 6)
                    send_sample((start + i) % n, pick_sample(), $urandom_range(99) < 10);
            if ($urandom_range(99) < 20)
                send_sample($urandom_range(3), pick_sample(), $urandom_range(99) < 10);
            send_process();
        end
    endtask

    task automatic test_random_rounds();
        int p;
        int goal;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       write_config(3'd4, 4'h0, 1'b1);
                1:       write_config(3'd4, 4'hF, 1'b0);
                2:       write_config(3'd1, 4'($urandom_range(15)), 1'b1);
                3:       write_config(3'd2, 4'b0101, 1'b0);
                4:       write_config(3'd3, 4'b1010, 1'b1);
                5:       write_config(3'd7, 4'($urandom_range(15)), 1'($urandom_range(1)));
                6:       write_config(3'd0, 4'($urandom_range(15)), 1'($urandom_range(1)));
                default: write_config(3'($urandom_range(7)), 4'($urandom_range(15)),
                                      1'($urandom_range(1)));
            endcase
            // one phase runs with no idle cycles on either side
            stall_en = (p != 3);
            goal = items_acting + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_acting < goal)
                fusion_round();
            settle();
        end
        stall_en = 1'b1;
    endtask

    // main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disarmed_start();
        test_inverted_overflow();
        test_error_priority();
        test_disarm_and_zero_count();
        test_random_rounds();
        $display("sent %0d items, %0d took effect, over %0d register settings",
                 items_sent, items_acting, settings_done);
        $display("checked %0d results: %0d averaged (%0d saturated), %0d errored samples",
                 results_checked, averaged_results, saturated_results, error_results);
        if (error_count == 0 && pending_fused.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
